/* design/slss_pkg.sv */
// package: widths, register indexes and root table for the scaled square root
package slss_pkg;

  localparam int SampleW = 32;
  localparam int RootW   = 16;
  localparam int KW      = 16;
  localparam int ShW     = 4;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] RegKScale    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegRootShift = 8'd1;

  localparam logic [KW-1:0] KScaleReset    = 16'd23170;
  localparam logic [ShW-1:0] RootShiftReset = 4'd7;
  localparam logic [14:0] RootMax = 15'd32767;

  function automatic logic [12:0] root_lut(input logic [9:0] i);
    logic [12:0] v;
    case (i)
      10'd0: v = 13'd0; 10'd1: v = 13'd256; 10'd2: v = 13'd362; 10'd3: v = 13'd443;
      10'd4: v = 13'd512; 10'd5: v = 13'd572; 10'd6: v = 13'd627; 10'd7: v = 13'd677;
      10'd8: v = 13'd724; 10'd9: v = 13'd768; 10'd10: v = 13'd810; 10'd11: v = 13'd849;
      10'd12: v = 13'd887; 10'd13: v = 13'd923; 10'd14: v = 13'd958; 10'd15: v = 13'd991;
      10'd16: v = 13'd1024; 10'd17: v = 13'd1056; 10'd18: v = 13'd1086; 10'd19: v = 13'd1116;
      10'd20: v = 13'd1145; 10'd21: v = 13'd1173; 10'd22: v = 13'd1201; 10'd23: v = 13'd1228;
      10'd24: v = 13'd1254; 10'd25: v = 13'd1280; 10'd26: v = 13'd1305; 10'd27: v = 13'd1330;
      10'd28: v = 13'd1355; 10'd29: v = 13'd1379; 10'd30: v = 13'd1402; 10'd31: v = 13'd1425;
      10'd32: v = 13'd1448; 10'd33: v = 13'd1471; 10'd34: v = 13'd1493; 10'd35: v = 13'd1515;
      10'd36: v = 13'd1536; 10'd37: v = 13'd1557; 10'd38: v = 13'd1578; 10'd39: v = 13'd1599;
      10'd40: v = 13'd1619; 10'd41: v = 13'd1639; 10'd42: v = 13'd1659; 10'd43: v = 13'd1679;
      10'd44: v = 13'd1698; 10'd45: v = 13'd1717; 10'd46: v = 13'd1736; 10'd47: v = 13'd1755;
      10'd48: v = 13'd1774; 10'd49: v = 13'd1792; 10'd50: v = 13'd1810; 10'd51: v = 13'd1828;
      10'd52: v = 13'd1846; 10'd53: v = 13'd1864; 10'd54: v = 13'd1881; 10'd55: v = 13'd1899;
      10'd56: v = 13'd1916; 10'd57: v = 13'd1933; 10'd58: v = 13'd1950; 10'd59: v = 13'd1966;
      10'd60: v = 13'd1983; 10'd61: v = 13'd1999; 10'd62: v = 13'd2016; 10'd63: v = 13'd2032;
      10'd64: v = 13'd2048; 10'd65: v = 13'd2064; 10'd66: v = 13'd2080; 10'd67: v = 13'd2095;
      10'd68: v = 13'd2111; 10'd69: v = 13'd2126; 10'd70: v = 13'd2142; 10'd71: v = 13'd2157;
      10'd72: v = 13'd2172; 10'd73: v = 13'd2187; 10'd74: v = 13'd2202; 10'd75: v = 13'd2217;
      10'd76: v = 13'd2232; 10'd77: v = 13'd2246; 10'd78: v = 13'd2261; 10'd79: v = 13'd2275;
      10'd80: v = 13'd2290; 10'd81: v = 13'd2304; 10'd82: v = 13'd2318; 10'd83: v = 13'd2332;
      10'd84: v = 13'd2346; 10'd85: v = 13'd2360; 10'd86: v = 13'd2374; 10'd87: v = 13'd2388;
      10'd88: v = 13'd2401; 10'd89: v = 13'd2415; 10'd90: v = 13'd2429; 10'd91: v = 13'd2442;
      10'd92: v = 13'd2455; 10'd93: v = 13'd2469; 10'd94: v = 13'd2482; 10'd95: v = 13'd2495;
      10'd96: v = 13'd2508; 10'd97: v = 13'd2521; 10'd98: v = 13'd2534; 10'd99: v = 13'd2547;
      10'd100: v = 13'd2560; 10'd101: v = 13'd2573; 10'd102: v = 13'd2585; 10'd103: v = 13'd2598;
      10'd104: v = 13'd2611; 10'd105: v = 13'd2623; 10'd106: v = 13'd2636; 10'd107: v = 13'd2648;
      10'd108: v = 13'd2660; 10'd109: v = 13'd2673; 10'd110: v = 13'd2685; 10'd111: v = 13'd2697;
      10'd112: v = 13'd2709; 10'd113: v = 13'd2721; 10'd114: v = 13'd2733; 10'd115: v = 13'd2745;
      10'd116: v = 13'd2757; 10'd117: v = 13'd2769; 10'd118: v = 13'd2781; 10'd119: v = 13'd2793;
      10'd120: v = 13'd2804; 10'd121: v = 13'd2816; 10'd122: v = 13'd2828; 10'd123: v = 13'd2839;
      10'd124: v = 13'd2851; 10'd125: v = 13'd2862; 10'd126: v = 13'd2874; 10'd127: v = 13'd2885;
      10'd128: v = 13'd2896; 10'd129: v = 13'd2908; 10'd130: v = 13'd2919; 10'd131: v = 13'd2930;
      10'd132: v = 13'd2941; 10'd133: v = 13'd2952; 10'd134: v = 13'd2963; 10'd135: v = 13'd2974;
      10'd136: v = 13'd2985; 10'd137: v = 13'd2996; 10'd138: v = 13'd3007; 10'd139: v = 13'd3018;
      10'd140: v = 13'd3029; 10'd141: v = 13'd3040; 10'd142: v = 13'd3051; 10'd143: v = 13'd3061;
      10'd144: v = 13'd3072; 10'd145: v = 13'd3083; 10'd146: v = 13'd3093; 10'd147: v = 13'd3104;
      10'd148: v = 13'd3114; 10'd149: v = 13'd3125; 10'd150: v = 13'd3135; 10'd151: v = 13'd3146;
      10'd152: v = 13'd3156; 10'd153: v = 13'd3167; 10'd154: v = 13'd3177; 10'd155: v = 13'd3187;
      10'd156: v = 13'd3197; 10'd157: v = 13'd3208; 10'd158: v = 13'd3218; 10'd159: v = 13'd3228;
      10'd160: v = 13'd3238; 10'd161: v = 13'd3248; 10'd162: v = 13'd3258; 10'd163: v = 13'd3268;
      10'd164: v = 13'd3278; 10'd165: v = 13'd3288; 10'd166: v = 13'd3298; 10'd167: v = 13'd3308;
      10'd168: v = 13'd3318; 10'd169: v = 13'd3328; 10'd170: v = 13'd3338; 10'd171: v = 13'd3348;
      10'd172: v = 13'd3357; 10'd173: v = 13'd3367; 10'd174: v = 13'd3377; 10'd175: v = 13'd3387;
      10'd176: v = 13'd3396; 10'd177: v = 13'd3406; 10'd178: v = 13'd3415; 10'd179: v = 13'd3425;
      10'd180: v = 13'd3435; 10'd181: v = 13'd3444; 10'd182: v = 13'd3454; 10'd183: v = 13'd3463;
      10'd184: v = 13'd3473; 10'd185: v = 13'd3482; 10'd186: v = 13'd3491; 10'd187: v = 13'd3501;
      10'd188: v = 13'd3510; 10'd189: v = 13'd3519; 10'd190: v = 13'd3529; 10'd191: v = 13'd3538;
      10'd192: v = 13'd3547; 10'd193: v = 13'd3556; 10'd194: v = 13'd3566; 10'd195: v = 13'd3575;
      10'd196: v = 13'd3584; 10'd197: v = 13'd3593; 10'd198: v = 13'd3602; 10'd199: v = 13'd3611;
      10'd200: v = 13'd3620; 10'd201: v = 13'd3629; 10'd202: v = 13'd3638; 10'd203: v = 13'd3647;
      10'd204: v = 13'd3656; 10'd205: v = 13'd3665; 10'd206: v = 13'd3674; 10'd207: v = 13'd3683;
      10'd208: v = 13'd3692; 10'd209: v = 13'd3701; 10'd210: v = 13'd3710; 10'd211: v = 13'd3719;
      10'd212: v = 13'd3727; 10'd213: v = 13'd3736; 10'd214: v = 13'd3745; 10'd215: v = 13'd3754;
      10'd216: v = 13'd3762; 10'd217: v = 13'd3771; 10'd218: v = 13'd3780; 10'd219: v = 13'd3788;
      10'd220: v = 13'd3797; 10'd221: v = 13'd3806; 10'd222: v = 13'd3814; 10'd223: v = 13'd3823;
      10'd224: v = 13'd3831; 10'd225: v = 13'd3840; 10'd226: v = 13'd3849; 10'd227: v = 13'd3857;
      10'd228: v = 13'd3866; 10'd229: v = 13'd3874; 10'd230: v = 13'd3882; 10'd231: v = 13'd3891;
      10'd232: v = 13'd3899; 10'd233: v = 13'd3908; 10'd234: v = 13'd3916; 10'd235: v = 13'd3924;
      10'd236: v = 13'd3933; 10'd237: v = 13'd3941; 10'd238: v = 13'd3949; 10'd239: v = 13'd3958;
      10'd240: v = 13'd3966; 10'd241: v = 13'd3974; 10'd242: v = 13'd3982; 10'd243: v = 13'd3991;
      10'd244: v = 13'd3999; 10'd245: v = 13'd4007; 10'd246: v = 13'd4015; 10'd247: v = 13'd4023;
      10'd248: v = 13'd4031; 10'd249: v = 13'd4040; 10'd250: v = 13'd4048; 10'd251: v = 13'd4056;
      10'd252: v = 13'd4064; 10'd253: v = 13'd4072; 10'd254: v = 13'd4080; 10'd255: v = 13'd4088;
      10'd256: v = 13'd4096; 10'd257: v = 13'd4104; 10'd258: v = 13'd4112; 10'd259: v = 13'd4120;
      10'd260: v = 13'd4128; 10'd261: v = 13'd4136; 10'd262: v = 13'd4144; 10'd263: v = 13'd4152;
      10'd264: v = 13'd4160; 10'd265: v = 13'd4167; 10'd266: v = 13'd4175; 10'd267: v = 13'd4183;
      10'd268: v = 13'd4191; 10'd269: v = 13'd4199; 10'd270: v = 13'd4207; 10'd271: v = 13'd4214;
      10'd272: v = 13'd4222; 10'd273: v = 13'd4230; 10'd274: v = 13'd4238; 10'd275: v = 13'd4245;
      10'd276: v = 13'd4253; 10'd277: v = 13'd4261; 10'd278: v = 13'd4268; 10'd279: v = 13'd4276;
      10'd280: v = 13'd4284; 10'd281: v = 13'd4291; 10'd282: v = 13'd4299; 10'd283: v = 13'd4307;
      10'd284: v = 13'd4314; 10'd285: v = 13'd4322; 10'd286: v = 13'd4329; 10'd287: v = 13'd4337;
      10'd288: v = 13'd4344; 10'd289: v = 13'd4352; 10'd290: v = 13'd4360; 10'd291: v = 13'd4367;
      10'd292: v = 13'd4375; 10'd293: v = 13'd4382; 10'd294: v = 13'd4389; 10'd295: v = 13'd4397;
      10'd296: v = 13'd4404; 10'd297: v = 13'd4412; 10'd298: v = 13'd4419; 10'd299: v = 13'd4427;
      10'd300: v = 13'd4434; 10'd301: v = 13'd4441; 10'd302: v = 13'd4449; 10'd303: v = 13'd4456;
      10'd304: v = 13'd4464; 10'd305: v = 13'd4471; 10'd306: v = 13'd4478; 10'd307: v = 13'd4485;
      10'd308: v = 13'd4493; 10'd309: v = 13'd4500; 10'd310: v = 13'd4507; 10'd311: v = 13'd4515;
      10'd312: v = 13'd4522; 10'd313: v = 13'd4529; 10'd314: v = 13'd4536; 10'd315: v = 13'd4544;
      10'd316: v = 13'd4551; 10'd317: v = 13'd4558; 10'd318: v = 13'd4565; 10'd319: v = 13'd4572;
      10'd320: v = 13'd4579; 10'd321: v = 13'd4587; 10'd322: v = 13'd4594; 10'd323: v = 13'd4601;
      10'd324: v = 13'd4608; 10'd325: v = 13'd4615; 10'd326: v = 13'd4622; 10'd327: v = 13'd4629;
      10'd328: v = 13'd4636; 10'd329: v = 13'd4643; 10'd330: v = 13'd4650; 10'd331: v = 13'd4658;
      10'd332: v = 13'd4665; 10'd333: v = 13'd4672; 10'd334: v = 13'd4679; 10'd335: v = 13'd4686;
      10'd336: v = 13'd4693; 10'd337: v = 13'd4700; 10'd338: v = 13'd4707; 10'd339: v = 13'd4713;
      10'd340: v = 13'd4720; 10'd341: v = 13'd4727; 10'd342: v = 13'd4734; 10'd343: v = 13'd4741;
      10'd344: v = 13'd4748; 10'd345: v = 13'd4755; 10'd346: v = 13'd4762; 10'd347: v = 13'd4769;
      10'd348: v = 13'd4776; 10'd349: v = 13'd4782; 10'd350: v = 13'd4789; 10'd351: v = 13'd4796;
      10'd352: v = 13'd4803; 10'd353: v = 13'd4810; 10'd354: v = 13'd4817; 10'd355: v = 13'd4823;
      10'd356: v = 13'd4830; 10'd357: v = 13'd4837; 10'd358: v = 13'd4844; 10'd359: v = 13'd4851;
      10'd360: v = 13'd4857; 10'd361: v = 13'd4864; 10'd362: v = 13'd4871; 10'd363: v = 13'd4877;
      10'd364: v = 13'd4884; 10'd365: v = 13'd4891; 10'd366: v = 13'd4898; 10'd367: v = 13'd4904;
      10'd368: v = 13'd4911; 10'd369: v = 13'd4918; 10'd370: v = 13'd4924; 10'd371: v = 13'd4931;
      10'd372: v = 13'd4938; 10'd373: v = 13'd4944; 10'd374: v = 13'd4951; 10'd375: v = 13'd4957;
      10'd376: v = 13'd4964; 10'd377: v = 13'd4971; 10'd378: v = 13'd4977; 10'd379: v = 13'd4984;
      10'd380: v = 13'd4990; 10'd381: v = 13'd4997; 10'd382: v = 13'd5003; 10'd383: v = 13'd5010;
      10'd384: v = 13'd5017; 10'd385: v = 13'd5023; 10'd386: v = 13'd5030; 10'd387: v = 13'd5036;
      10'd388: v = 13'd5043; 10'd389: v = 13'd5049; 10'd390: v = 13'd5056; 10'd391: v = 13'd5062;
      10'd392: v = 13'd5069; 10'd393: v = 13'd5075; 10'd394: v = 13'd5081; 10'd395: v = 13'd5088;
      10'd396: v = 13'd5094; 10'd397: v = 13'd5101; 10'd398: v = 13'd5107; 10'd399: v = 13'd5114;
      10'd400: v = 13'd5120; 10'd401: v = 13'd5126; 10'd402: v = 13'd5133; 10'd403: v = 13'd5139;
      10'd404: v = 13'd5146; 10'd405: v = 13'd5152; 10'd406: v = 13'd5158; 10'd407: v = 13'd5165;
      10'd408: v = 13'd5171; 10'd409: v = 13'd5177; 10'd410: v = 13'd5184; 10'd411: v = 13'd5190;
      10'd412: v = 13'd5196; 10'd413: v = 13'd5203; 10'd414: v = 13'd5209; 10'd415: v = 13'd5215;
      10'd416: v = 13'd5221; 10'd417: v = 13'd5228; 10'd418: v = 13'd5234; 10'd419: v = 13'd5240;
      10'd420: v = 13'd5246; 10'd421: v = 13'd5253; 10'd422: v = 13'd5259; 10'd423: v = 13'd5265;
      10'd424: v = 13'd5271; 10'd425: v = 13'd5278; 10'd426: v = 13'd5284; 10'd427: v = 13'd5290;
      10'd428: v = 13'd5296; 10'd429: v = 13'd5302; 10'd430: v = 13'd5309; 10'd431: v = 13'd5315;
      10'd432: v = 13'd5321; 10'd433: v = 13'd5327; 10'd434: v = 13'd5333; 10'd435: v = 13'd5339;
      10'd436: v = 13'd5345; 10'd437: v = 13'd5352; 10'd438: v = 13'd5358; 10'd439: v = 13'd5364;
      10'd440: v = 13'd5370; 10'd441: v = 13'd5376; 10'd442: v = 13'd5382; 10'd443: v = 13'd5388;
      10'd444: v = 13'd5394; 10'd445: v = 13'd5400; 10'd446: v = 13'd5406; 10'd447: v = 13'd5412;
      10'd448: v = 13'd5418; 10'd449: v = 13'd5425; 10'd450: v = 13'd5431; 10'd451: v = 13'd5437;
      10'd452: v = 13'd5443; 10'd453: v = 13'd5449; 10'd454: v = 13'd5455; 10'd455: v = 13'd5461;
      10'd456: v = 13'd5467; 10'd457: v = 13'd5473; 10'd458: v = 13'd5479; 10'd459: v = 13'd5485;
      10'd460: v = 13'd5491; 10'd461: v = 13'd5497; 10'd462: v = 13'd5503; 10'd463: v = 13'd5508;
      10'd464: v = 13'd5514; 10'd465: v = 13'd5520; 10'd466: v = 13'd5526; 10'd467: v = 13'd5532;
      10'd468: v = 13'd5538; 10'd469: v = 13'd5544; 10'd470: v = 13'd5550; 10'd471: v = 13'd5556;
      10'd472: v = 13'd5562; 10'd473: v = 13'd5568; 10'd474: v = 13'd5574; 10'd475: v = 13'd5579;
      10'd476: v = 13'd5585; 10'd477: v = 13'd5591; 10'd478: v = 13'd5597; 10'd479: v = 13'd5603;
      10'd480: v = 13'd5609; 10'd481: v = 13'd5615; 10'd482: v = 13'd5620; 10'd483: v = 13'd5626;
      10'd484: v = 13'd5632; 10'd485: v = 13'd5638; 10'd486: v = 13'd5644; 10'd487: v = 13'd5649;
      10'd488: v = 13'd5655; 10'd489: v = 13'd5661; 10'd490: v = 13'd5667; 10'd491: v = 13'd5673;
      10'd492: v = 13'd5678; 10'd493: v = 13'd5684; 10'd494: v = 13'd5690; 10'd495: v = 13'd5696;
      10'd496: v = 13'd5701; 10'd497: v = 13'd5707; 10'd498: v = 13'd5713; 10'd499: v = 13'd5719;
      10'd500: v = 13'd5724; 10'd501: v = 13'd5730; 10'd502: v = 13'd5736; 10'd503: v = 13'd5741;
      10'd504: v = 13'd5747; 10'd505: v = 13'd5753; 10'd506: v = 13'd5759; 10'd507: v = 13'd5764;
      10'd508: v = 13'd5770; 10'd509: v = 13'd5776; 10'd510: v = 13'd5781; 10'd511: v = 13'd5787;
      10'd512: v = 13'd5793;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // stage 1 to stage 2: normalized magnitude
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic        last;
    logic [8:0]  idx;
    logic [7:0]  frac;
    logic [4:0]  sr;     // even right shift, 0..14, or left shift when sr_left
    logic        sr_left;
  } slss_norm_t;

  // stage 2 to stage 3: table values
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic        last;
    logic [12:0] y0;
    logic [12:0] y1;
    logic [7:0]  frac;
    logic [4:0]  sr;
    logic        sr_left;
  } slss_lut_t;

  // stage 3 to stage 4: integer root
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic        last;
    logic [15:0] rt;
  } slss_root_t;

  // stage 4 to stage 5: scaled product
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic        last;
    logic [31:0] prod;
  } slss_prod_t;

endpackage

/* design/slss_if.sv */
// interfaces: sample, result and configuration channels
interface slss_in_if;
  import slss_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               last_in;
  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

interface slss_out_if;
  import slss_pkg::*;
  logic             valid;
  logic             ready;
  logic [RootW-1:0] root;
  logic             last_out;
  modport source (output valid, output root, output last_out, input ready);
  modport sink (input valid, input root, input last_out, output ready);
endinterface

interface slss_cfg_if;
  import slss_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/slss_root.sv */
// square root datapath: normalize, table lookup, interpolate and shift back
module slss_root
  import slss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SampleW-1:0] sample,
  input  logic               last_in,
  output logic               out_valid,
  output slss_root_t         out_data
);

  logic        v1, v2, v3;
  slss_norm_t  s1, s1_next;
  slss_lut_t   s2, s2_next;
  slss_root_t  s3_next;

  // stage 1: magnitude, leading one, even shift
  always_comb begin
    logic [30:0] mag;
    logic [4:0]  top;
    logic [5:0]  srs;
    logic [30:0] sh;
    mag = '0;
    top = '0;
    srs = '0;
    sh  = '0;
    if (sample[31]) begin
      if (sample == 32'h8000_0000) mag = 31'h7FFF_FFFF;
      else mag = 31'(32'd0 - sample);
    end else begin
      mag = sample[30:0];
    end
    for (int i = 0; i < 31; i++) begin
      if (mag[i]) top = 5'(i);
    end
    srs = 6'({1'b0, top}) - 6'd16;
    if (srs[0]) srs = srs + 6'd1;
    if (srs[5]) sh = mag << (6'd0 - srs);
    else sh = mag >> srs;
    s1_next.zero    = (sample == '0);
    s1_next.neg     = sample[31];
    s1_next.last    = last_in;
    s1_next.sr_left = srs[5];
    s1_next.sr      = srs[5] ? 5'(6'd0 - srs) : srs[4:0];
    // normalization keeps the index below 512, so no clamp is needed
    s1_next.idx     = sh[16:8];
    s1_next.frac    = sh[7:0];
  end

  // stage 2: table reads
  always_comb begin
    s2_next.zero    = s1.zero;
    s2_next.neg     = s1.neg;
    s2_next.last    = s1.last;
    s2_next.y0      = root_lut({1'b0, s1.idx});
    s2_next.y1      = root_lut(10'({1'b0, s1.idx}) + 10'd1);
    s2_next.frac    = s1.frac;
    s2_next.sr      = s1.sr;
    s2_next.sr_left = s1.sr_left;
  end

  // stage 3: interpolate and shift back by half the normalizing shift, minus four
  always_comb begin
    logic [20:0] dm;
    logic [12:0] ip;
    logic [4:0]  half;
    dm = 21'(s2.y1 - s2.y0) * 21'(s2.frac);
    ip = s2.y0 + 13'(dm >> 8);
    half = s2.sr >> 1;
    s3_next.zero = s2.zero;
    s3_next.neg  = s2.neg;
    s3_next.last = s2.last;
    if (s2.sr_left) s3_next.rt = 16'(ip >> (half + 5'd4));
    else if (half >= 5'd4) s3_next.rt = 16'({3'b0, ip} << (half - 5'd4));
    else s3_next.rt = 16'(ip >> (5'd4 - half));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= s1_next;
      s2       <= s2_next;
      out_data <= s3_next;
    end
  end

  assign out_valid = v3;

endmodule

/* design/slss_scale.sv */
// scaling: multiply by gain, round, shift, saturate and restore sign
module slss_scale
  import slss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  slss_root_t       in_data,
  input  logic [KW-1:0]    k_scale,
  input  logic [ShW-1:0]   root_shift,
  output logic             out_valid,
  output logic [RootW-1:0] root,
  output logic             last_out
);

  logic        v4;
  slss_prod_t  p;
  logic [RootW-1:0] root_next;

  always_comb begin
    logic [32:0] sum;
    logic [32:0] y;
    logic [32:0] rnd;
    logic [14:0] mag;
    rnd = (root_shift == '0) ? 33'd0 : (33'd1 << (root_shift - 4'd1));
    sum = {1'b0, p.prod} + rnd;
    y   = sum >> root_shift;
    mag = (y > 33'(RootMax)) ? RootMax : y[14:0];
    if (p.zero) mag = '0;
    root_next = p.neg ? 16'(17'h10000 - 17'(mag)) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p.zero   <= in_data.zero;
      p.neg    <= in_data.neg;
      p.last   <= in_data.last;
      p.prod   <= 32'(k_scale) * 32'(in_data.rt);
      root     <= root_next;
      last_out <= p.last;
    end
  end

endmodule

/* design/signed_lut_sqrt_scaler.sv */
// top level: signed scaled square root with table interpolation
// latency: five register stages (normalize, table, root, product, result)
// throughput: one sample per cycle; a stalled output freezes the whole pipeline
// input ready is held only while the last stage holds an untaken result
// reset: synchronous; clears valid bits, k_scale to 23170 and root_shift to 7
// configuration writes are always taken; write only while the pipeline is empty
module signed_lut_sqrt_scaler
  import slss_pkg::*;
(
  input logic clk,
  input logic rst,
  slss_in_if.sink    in_ch,
  slss_out_if.source out_ch,
  slss_cfg_if.sink   cfg
);

  logic          en;
  logic          rv;
  slss_root_t    rd;
  logic [KW-1:0]  k_scale;
  logic [ShW-1:0] root_shift;

  // pipeline advances unless the output holds a result not yet taken
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      k_scale    <= KScaleReset;
      root_shift <= RootShiftReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegKScale:    k_scale <= cfg.data[KW-1:0];
        RegRootShift: root_shift <= cfg.data[ShW-1:0];
        default: ;
      endcase
    end
  end

  slss_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .sample    (in_ch.sample),
    .last_in   (in_ch.last_in),
    .out_valid (rv),
    .out_data  (rd)
  );

  slss_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (rv),
    .in_data    (rd),
    .k_scale    (k_scale),
    .root_shift (root_shift),
    .out_valid  (out_ch.valid),
    .root       (out_ch.root),
    .last_out   (out_ch.last_out)
  );

endmodule
